// ===== hdl/tf256_pkg.sv =====
`timescale 1ns / 1ps

package tf256_pkg;

  localparam int WORD_W         = 64;
  localparam int NUM_WORDS      = 4;
  localparam int NUM_ROUNDS     = 72;
  localparam int ROUNDS_PER_KEY = 4;
  localparam int NUM_GROUPS     = NUM_ROUNDS / ROUNDS_PER_KEY;
  localparam int GROUP_LEN      = ROUNDS_PER_KEY + 1;
  localparam int NUM_STAGES     = 1 + NUM_GROUPS * GROUP_LEN;
  localparam int ROUND_W        = $clog2(NUM_ROUNDS);
  localparam int SUBKEY_W       = $clog2(NUM_GROUPS + 1);
  localparam int ROT_W          = 6;

  localparam logic [WORD_W-1:0] KEY_PARITY = 64'h1BD1_1BDA_A9FC_1A22;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word4_t;

  typedef struct packed {
    logic   valid;
    logic   cmd;
    word4_t key;
    word4_t word;
  } tf256_stage_t;

  // Rotation table: row selects the round within a group of eight, col picks
  // the amount for the first or the second word pair.
  function automatic logic [ROT_W-1:0] rot_amount(input logic [2:0] row, input logic col);
    logic [ROT_W-1:0] amt;
    case (row)
      3'd0:    amt = col ? 6'd16 : 6'd14;
      3'd1:    amt = col ? 6'd57 : 6'd52;
      3'd2:    amt = col ? 6'd40 : 6'd23;
      3'd3:    amt = col ? 6'd37 : 6'd5;
      3'd4:    amt = col ? 6'd33 : 6'd25;
      3'd5:    amt = col ? 6'd12 : 6'd46;
      3'd6:    amt = col ? 6'd22 : 6'd58;
      default: amt = 6'd32;
    endcase
    return amt;
  endfunction

endpackage

// ===== hdl/tf256_round_cell.sv =====
`timescale 1ns / 1ps

module tf256_round_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [tf256_pkg::ROUND_W-1:0]    round_idx,
  input  tf256_pkg::tf256_stage_t          d_in,
  output tf256_pkg::tf256_stage_t          d_out
);
  import tf256_pkg::*;

  logic             valid;
  logic             cmd;
  word4_t           key;
  word4_t           word;
  word4_t           word_next;
  logic             pair_even;
  logic [2:0]       rot_idx;
  logic [ROT_W-1:0] rot_a;
  logic [ROT_W-1:0] rot_b;
  logic [WORD_W-1:0] b_a;
  logic [WORD_W-1:0] b_b;
  logic [WORD_W-1:0] ma_a;
  logic [WORD_W-1:0] mb_a;
  logic [WORD_W-1:0] ma_b;
  logic [WORD_W-1:0] mb_b;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr64(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} >> n;
    return t[WORD_W-1:0];
  endfunction

  // Decryption walks the rounds backward, so its round number is the mirror
  // of this cell's position: parity flips and the table row is inverted.
  always_comb begin
    pair_even = (d_in.cmd == CMD_DECRYPT) ? round_idx[0] : ~round_idx[0];
    rot_idx   = (d_in.cmd == CMD_DECRYPT) ? ~round_idx[2:0] : round_idx[2:0];
    rot_a     = rot_amount(rot_idx, 1'b0);
    rot_b     = rot_amount(rot_idx, 1'b1);
    b_a       = pair_even ? d_in.word[1] : d_in.word[3];
    b_b       = pair_even ? d_in.word[3] : d_in.word[1];
    if (d_in.cmd == CMD_DECRYPT) begin
      mb_a = rotr64(b_a ^ d_in.word[0], rot_a);
      ma_a = d_in.word[0] - mb_a;
      mb_b = rotr64(b_b ^ d_in.word[2], rot_b);
      ma_b = d_in.word[2] - mb_b;
    end else begin
      ma_a = d_in.word[0] + b_a;
      mb_a = rotl64(b_a, rot_a) ^ ma_a;
      ma_b = d_in.word[2] + b_b;
      mb_b = rotl64(b_b, rot_b) ^ ma_b;
    end
    word_next[0] = ma_a;
    word_next[2] = ma_b;
    word_next[1] = pair_even ? mb_a : mb_b;
    word_next[3] = pair_even ? mb_b : mb_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd  <= d_in.cmd;
      key  <= d_in.key;
      word <= word_next;
    end
  end

  assign d_out = '{valid: valid, cmd: cmd, key: key, word: word};

endmodule

// ===== hdl/tf256_key_cell.sv =====
`timescale 1ns / 1ps

module tf256_key_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [tf256_pkg::SUBKEY_W-1:0]   subkey_idx,
  input  tf256_pkg::tf256_stage_t          d_in,
  output tf256_pkg::tf256_stage_t          d_out
);
  import tf256_pkg::*;

  logic                   valid;
  logic                   cmd;
  word4_t                 key;
  word4_t                 word;
  word4_t                 word_next;
  word4_t                 subkey;
  logic [4:0][WORD_W-1:0] key_ext;
  logic [SUBKEY_W-1:0]    s;
  logic [2:0]             base;
  logic [2:0]             sel;

  function automatic logic [2:0] mod5(input logic [SUBKEY_W-1:0] v);
    logic [SUBKEY_W-1:0] r;
    r = v;
    if (r >= SUBKEY_W'(20)) r = r - SUBKEY_W'(20);
    if (r >= SUBKEY_W'(10)) r = r - SUBKEY_W'(10);
    if (r >= SUBKEY_W'(5))  r = r - SUBKEY_W'(5);
    return r[2:0];
  endfunction

  // Decryption injects the subkeys in reverse order.
  always_comb begin
    s = (d_in.cmd == CMD_DECRYPT) ? SUBKEY_W'(NUM_GROUPS) - subkey_idx : subkey_idx;
    key_ext[0] = d_in.key[0];
    key_ext[1] = d_in.key[1];
    key_ext[2] = d_in.key[2];
    key_ext[3] = d_in.key[3];
    key_ext[4] = KEY_PARITY ^ d_in.key[0] ^ d_in.key[1] ^ d_in.key[2] ^ d_in.key[3];
    base = mod5(s);
    for (int i = 0; i < NUM_WORDS; i++) begin
      sel = base + 3'(i);
      if (sel >= 3'd5) sel = sel - 3'd5;
      subkey[i] = key_ext[sel];
    end
    subkey[NUM_WORDS-1] = subkey[NUM_WORDS-1] + WORD_W'(s);
    for (int i = 0; i < NUM_WORDS; i++) begin
      word_next[i] = (d_in.cmd == CMD_DECRYPT) ? d_in.word[i] - subkey[i]
                                               : d_in.word[i] + subkey[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd  <= d_in.cmd;
      key  <= d_in.key;
      word <= word_next;
    end
  end

  assign d_out = '{valid: valid, cmd: cmd, key: key, word: word};

endmodule

// ===== hdl/threefish256_block_cipher.sv =====
// Threefish-256 cipher with a zero tweak, 72 rounds, fully pipelined.
// Input channel: cmd (0 encrypt, 1 decrypt), key_word0..3 and block_word0..3
// move in one transfer when in_valid is high and in_stall is low. The key
// comes with every block and travels down the pipeline beside it, so blocks
// under different keys and commands may be mixed freely.
// Output channel: out_word0..3 move when out_valid is high and out_stall is
// low. The output is the register of the last cell.
// The pipeline is a chain of 91 cells: one subkey cell, then eighteen groups
// of four round cells followed by a subkey cell. Each cell registers its word.
// A block passes through the register of every cell in turn; throughput
// is one block per cycle while the receiver keeps out_stall low.
// When a finished block waits with out_stall high, the whole chain holds
// and in_stall rises in the same cycle; otherwise in_stall stays low, and
// empty slots in the chain move on without blocking anything.
// Reset (rst, synchronous) clears the valid bit of every cell; the cmd, key
// and word registers are not reset, and nothing carries over from one block to the next.
`timescale 1ns / 1ps

module threefish256_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [63:0] key_word3,
  input  logic [63:0] block_word0,
  input  logic [63:0] block_word1,
  input  logic [63:0] block_word2,
  input  logic [63:0] block_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2,
  output logic [63:0] out_word3
);
  import tf256_pkg::*;

  // chain[n] is the output of cell n; chain[0] is the input channel.
  tf256_stage_t chain [NUM_STAGES+1];
  logic         en;

  // The chain moves as one unit: it halts only when the last cell holds a
  // block that the receiver does not take.
  assign en       = !(chain[NUM_STAGES].valid && out_stall);
  assign in_stall = !en;

  assign chain[0] = '{valid: in_valid,
                      cmd:   cmd,
                      key:   {key_word3, key_word2, key_word1, key_word0},
                      word:  {block_word3, block_word2, block_word1, block_word0}};

  // Whitening with the first subkey (the last one when decrypting).
  tf256_key_cell u_key_first (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .subkey_idx (SUBKEY_W'(0)),
    .d_in       (chain[0]),
    .d_out      (chain[1])
  );

  genvar g, r;
  generate
    for (g = 0; g < NUM_GROUPS; g++) begin : g_group
      for (r = 0; r < ROUNDS_PER_KEY; r++) begin : g_round
        tf256_round_cell u_round (
          .clk       (clk),
          .rst       (rst),
          .en        (en),
          .round_idx (ROUND_W'(g * ROUNDS_PER_KEY + r)),
          .d_in      (chain[1 + g * GROUP_LEN + r]),
          .d_out     (chain[2 + g * GROUP_LEN + r])
        );
      end
      // Subkey injection after every fourth round.
      tf256_key_cell u_key (
        .clk        (clk),
        .rst        (rst),
        .en         (en),
        .subkey_idx (SUBKEY_W'(g + 1)),
        .d_in       (chain[1 + g * GROUP_LEN + ROUNDS_PER_KEY]),
        .d_out      (chain[2 + g * GROUP_LEN + ROUNDS_PER_KEY])
      );
    end
  endgenerate

  assign out_valid = chain[NUM_STAGES].valid;
  assign out_word0 = chain[NUM_STAGES].word[0];
  assign out_word1 = chain[NUM_STAGES].word[1];
  assign out_word2 = chain[NUM_STAGES].word[2];
  assign out_word3 = chain[NUM_STAGES].word[3];

endmodule

// ===== hdl/tf256_checker.sv =====
`timescale 1ns / 1ps

module tf256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_word0,
  input logic [63:0] out_word1,
  input logic [63:0] out_word2,
  input logic [63:0] out_word3
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word0) && $stable(out_word1)
                               && $stable(out_word2) && $stable(out_word3))
    else $error("stalled result changed");

  // The input is held back only by a result that waits at the output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // When the output is free the pipeline keeps taking blocks.
  assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // No result comes out of a cleared pipeline.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind threefish256_block_cipher tf256_checker u_tf256_checker (.*);
